// ===== hw/rtl/bst_pkg.sv =====
// Package for the byte stream tokenizer: token and scan mode codes,
// character classification and the records passed between the stages.
// No dependencies.
package bst_pkg;

    typedef enum logic [3:0] {
        KIND_EOF    = 4'd0,
        KIND_IDENT  = 4'd1,
        KIND_NUMBER = 4'd2,
        KIND_LPAREN = 4'd3,
        KIND_RPAREN = 4'd4,
        KIND_COMMA  = 4'd5,
        KIND_ASSIGN = 4'd6,
        KIND_SEMI   = 4'd7,
        KIND_ERROR  = 4'd8
    } kind_t;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_IDENT = 3'd1,
        MODE_DEC   = 3'd2,
        MODE_ZERO  = 3'd3,
        MODE_HEX   = 3'd4
    } mode_t;

    localparam logic [15:0] LEN_MAX = 16'hFFFF;
    localparam logic [3:0]  HEX_LETTER_BIAS = 4'd9;  // 'a'/'A' low nibble 1 -> 10

    localparam logic [7:0] CH_END    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_ASSIGN = 8'h3D;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_UX     = 8'h58;
    localparam logic [7:0] CH_UZ     = 8'h5A;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF_HEX = 8'h66;
    localparam logic [7:0] CH_LX     = 8'h78;
    localparam logic [7:0] CH_LZ     = 8'h7A;

    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic       is_end;
        logic       is_space;
        logic       is_word_lead;
        logic       is_dec;
        logic       is_zero;
        logic       is_x;
        logic       is_hex;
        logic [3:0] nibble;
        kind_t      single_kind;
    } char_info_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] start;
        logic [15:0] length;
        logic [31:0] value;
        logic        last;
    } token_t;

    function automatic char_info_t classify(logic [7:0] b);
        char_info_t c;
        logic       upper;
        logic       lower;
        logic       hex_letter;
        upper = (b >= CH_UA) && (b <= CH_UZ);
        lower = (b >= CH_LA) && (b <= CH_LZ);
        hex_letter = ((b >= CH_UA) && (b <= CH_UF)) || ((b >= CH_LA) && (b <= CH_LF_HEX));
        c.is_end       = (b == CH_END);
        c.is_space     = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
        c.is_word_lead = upper || lower || (b == CH_USCORE);
        c.is_dec       = (b >= CH_ZERO) && (b <= CH_NINE);
        c.is_zero      = (b == CH_ZERO);
        c.is_x         = (b == CH_LX) || (b == CH_UX);
        c.is_hex       = c.is_dec || hex_letter;
        c.nibble       = hex_letter ? (b[3:0] + HEX_LETTER_BIAS) : b[3:0];
        unique case (b)
            CH_LPAREN: c.single_kind = KIND_LPAREN;
            CH_RPAREN: c.single_kind = KIND_RPAREN;
            CH_COMMA:  c.single_kind = KIND_COMMA;
            CH_ASSIGN: c.single_kind = KIND_ASSIGN;
            CH_SEMI:   c.single_kind = KIND_SEMI;
            default:   c.single_kind = KIND_ERROR;
        endcase
        return c;
    endfunction

endpackage

// ===== hw/rtl/bst_if.sv =====
// Valid/ready channel interfaces for the tokenizer: source bytes in,
// tokens out. No dependencies.
interface bst_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;

    modport source (output valid, output char_byte, input ready);
    modport sink   (input valid, input char_byte, output ready);
endinterface

interface bst_token_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [31:0] token_value;
    logic        last_of_run;

    modport source (output valid, output token_kind, output token_start,
                    output token_length, output token_value, output last_of_run,
                    input ready);
    modport sink   (input valid, input token_kind, input token_start,
                    input token_length, input token_value, input last_of_run,
                    output ready);
endinterface

// ===== hw/rtl/bst_front.sv =====
// Front stage: accepts source bytes and registers their character class.
// Depends on bst_pkg and bst_if.
module bst_front (
    input  logic               clk,
    input  logic               rst_n,
    bst_char_if.sink           chars,
    output logic               push_valid,
    input  logic               push_ready,
    output bst_pkg::char_info_t push_data
);
    import bst_pkg::*;

    logic       valid_reg;
    char_info_t info_reg;

    assign chars.ready = !valid_reg || push_ready;
    assign push_valid  = valid_reg;
    assign push_data   = info_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (chars.ready)
        begin
            valid_reg <= chars.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
        begin
            info_reg <= classify(chars.char_byte);
        end
    end

endmodule

// ===== hw/rtl/bst_fifo.sv =====
// Short queue of classified bytes between the front and the scanner.
// Depends on bst_pkg.
module bst_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  bst_pkg::char_info_t push_data,
    output logic                pop_valid,
    input  logic                pop_ready,
    output bst_pkg::char_info_t pop_data
);
    import bst_pkg::*;

    char_info_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_BITS-1:0] count_reg;
    logic                      do_push;
    logic                      do_pop;

    assign push_ready = (count_reg != QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    function automatic logic [QUEUE_PTR_BITS-1:0] bump(logic [QUEUE_PTR_BITS-1:0] p);
        return (p == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + QUEUE_PTR_BITS'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + QUEUE_CNT_BITS'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - QUEUE_CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/bst_back.sv =====
// Scanner: runs the token state machine on classified bytes and drives the
// token channel through an output register plus a slot for a second token.
// Depends on bst_pkg and bst_if.
module bst_back #(
    parameter int POSITION_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_ready,
    input  bst_pkg::char_info_t q_data,
    bst_token_if.source         tokens
);
    import bst_pkg::*;

    mode_t                    mode_reg,   mode_next;
    logic [POSITION_BITS-1:0] pos_reg,    pos_next;
    logic [POSITION_BITS-1:0] pstart_reg, pstart_next;
    logic [15:0]              plen_reg,   plen_next;
    logic [31:0]              pval_reg,   pval_next;

    logic   out_valid_reg;
    token_t out_reg;
    logic   second_valid_reg;
    token_t second_reg;

    token_t      tok_a;
    token_t      tok_b;
    logic        have_a;
    logic        have_b;
    logic        absorb;
    logic        active;
    mode_t       ext_mode;
    logic [31:0] ext_val;
    logic [31:0] dec_val;
    logic [31:0] hex_val;
    logic        out_free;
    logic        take;

    // times ten as shift-and-add
    assign dec_val = (pval_reg << 3) + (pval_reg << 1) + 32'(q_data.nibble);
    assign hex_val = {pval_reg[27:0], q_data.nibble};

    always_comb
    begin
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        pstart_next = pstart_reg;
        plen_next   = plen_reg;
        pval_next   = pval_reg;
        tok_a       = '0;
        tok_b       = '0;
        have_a      = 1'b0;
        have_b      = 1'b0;
        absorb      = 1'b0;
        active      = 1'b0;
        ext_mode    = mode_reg;
        ext_val     = pval_reg;

        unique case (mode_reg)
            MODE_IDENT:
            begin
                active = 1'b1;
                absorb = q_data.is_word_lead || q_data.is_dec;
            end
            MODE_DEC:
            begin
                active  = 1'b1;
                absorb  = q_data.is_dec;
                ext_val = dec_val;
            end
            MODE_ZERO:
            begin
                active   = 1'b1;
                absorb   = q_data.is_x || q_data.is_dec;
                ext_mode = q_data.is_x ? MODE_HEX : MODE_DEC;
                ext_val  = q_data.is_x ? pval_reg : dec_val;
            end
            MODE_HEX:
            begin
                active  = 1'b1;
                absorb  = q_data.is_hex;
                ext_val = hex_val;
            end
            default:
            begin
                active = 1'b0;
            end
        endcase

        if (absorb)
        begin
            mode_next = ext_mode;
            pval_next = ext_val;
            plen_next = (plen_reg == LEN_MAX) ? plen_reg : plen_reg + 16'd1;
            pos_next  = pos_reg + POSITION_BITS'(1);
        end
        else
        begin
            if (active)
            begin
                have_a       = 1'b1;
                tok_a.kind   = (mode_reg == MODE_IDENT) ? KIND_IDENT : KIND_NUMBER;
                tok_a.start  = 16'(pstart_reg);
                tok_a.length = plen_reg;
                tok_a.value  = (mode_reg == MODE_IDENT) ? 32'd0 : pval_reg;
            end
            mode_next = MODE_IDLE;

            if (q_data.is_end)
            begin
                have_b       = 1'b1;
                tok_b.kind   = KIND_EOF;
                tok_b.start  = 16'(pos_reg);
                tok_b.length = 16'd0;
                pos_next     = '0;
            end
            else if (q_data.is_space)
            begin
                pos_next = pos_reg + POSITION_BITS'(1);
            end
            else if (q_data.is_word_lead || q_data.is_dec)
            begin
                pstart_next = pos_reg;
                plen_next   = 16'd1;
                if (q_data.is_word_lead)
                begin
                    mode_next = MODE_IDENT;
                    pval_next = 32'd0;
                end
                else
                begin
                    mode_next = q_data.is_zero ? MODE_ZERO : MODE_DEC;
                    pval_next = 32'(q_data.nibble);
                end
                pos_next = pos_reg + POSITION_BITS'(1);
            end
            else
            begin
                have_b       = 1'b1;
                tok_b.kind   = q_data.single_kind;
                tok_b.start  = 16'(pos_reg);
                tok_b.length = 16'd1;
                pos_next     = pos_reg + POSITION_BITS'(1);
            end
        end

        tok_a.last = !have_b;
        tok_b.last = 1'b1;
    end

    assign out_free = !out_valid_reg || tokens.ready;
    assign take     = q_valid && !second_valid_reg && out_free;
    assign q_ready  = take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_IDLE;
            pos_reg          <= '0;
            pstart_reg       <= '0;
            plen_reg         <= '0;
            pval_reg         <= '0;
            out_valid_reg    <= 1'b0;
            second_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                mode_reg   <= mode_next;
                pos_reg    <= pos_next;
                pstart_reg <= pstart_next;
                plen_reg   <= plen_next;
                pval_reg   <= pval_next;
            end
            if (out_free)
            begin
                if (second_valid_reg)
                begin
                    out_valid_reg    <= 1'b1;
                    second_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg    <= take && (have_a || have_b);
                    second_valid_reg <= take && have_a && have_b;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (second_valid_reg)
            begin
                out_reg <= second_reg;
            end
            else if (take)
            begin
                out_reg    <= have_a ? tok_a : tok_b;
                second_reg <= tok_b;
            end
        end
    end

    assign tokens.valid        = out_valid_reg;
    assign tokens.token_kind   = out_reg.kind;
    assign tokens.token_start  = out_reg.start;
    assign tokens.token_length = out_reg.length;
    assign tokens.token_value  = out_reg.value;
    assign tokens.last_of_run  = out_reg.last;

endmodule

// ===== hw/rtl/byte_stream_tokenizer_core.sv =====
// Byte stream tokenizer top level: front classifier, short queue, scanner.
// The front stage registers a byte's class, the short queue holds it and the
// scanner registers its tokens, a second one held in a slot until the first is taken.
// Throughput: one byte per cycle while the token channel accepts; a byte that closes
// a token and also emits one of its own stalls the scanner until its second token moves to the output register.
// Reset: asynchronous, clears all control and scan state (position 0, idle).
// Depends on bst_pkg, bst_if, bst_front, bst_fifo and bst_back.
module byte_stream_tokenizer_core #(
    parameter int POSITION_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    bst_char_if.sink    chars,
    bst_token_if.source tokens
);
    import bst_pkg::*;

    logic       push_valid;
    logic       push_ready;
    char_info_t push_data;
    logic       pop_valid;
    logic       pop_ready;
    char_info_t pop_data;

    bst_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .chars      (chars),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    bst_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    bst_back #(
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (pop_valid),
        .q_ready (pop_ready),
        .q_data  (pop_data),
        .tokens  (tokens)
    );

endmodule

// ===== tb/token_stream_checker.sv =====
// Checker for the byte stream tokenizer: watches the byte and token channels,
// predicts the token beats from the accepted bytes and compares field by field.
// Depends on bst_pkg and bst_if.
module token_stream_checker #(
    parameter int POSITION_BITS = 16
) (
    input  logic   clk,
    input  logic   rst_n,
    bst_char_if    chars,
    bst_token_if   tokens,
    output int     fail_count,
    output int     pending_count
);
    import bst_pkg::*;

    mode_t                    scan_mode;
    logic [POSITION_BITS-1:0] text_pos;
    logic [POSITION_BITS-1:0] tok_start;
    logic [15:0]              tok_len;
    logic [31:0]              tok_val;
    token_t                   expected_tokens[$];

    function automatic bit is_letter(logic [7:0] b);
        return ((b >= CH_LA) && (b <= CH_LZ)) || ((b >= CH_UA) && (b <= CH_UZ)) ||
               (b == CH_USCORE);
    endfunction

    function automatic bit is_dec(logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic bit is_hexch(logic [7:0] b);
        return is_dec(b) || ((b >= CH_LA) && (b <= CH_LF_HEX)) ||
               ((b >= CH_UA) && (b <= CH_UF));
    endfunction

    function automatic logic [3:0] hex_nibble(logic [7:0] b);
        logic [7:0] v;
        if (is_dec(b))
            v = b - CH_ZERO;
        else if (b >= CH_LA)
            v = b - CH_LA + 8'd10;
        else
            v = b - CH_UA + 8'd10;
        return v[3:0];
    endfunction

    function automatic bit is_blank(logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
    endfunction

    function automatic void queue_token(kind_t k, logic [POSITION_BITS-1:0] from,
                                        logic [15:0] len, logic [31:0] val);
        token_t t;
        t.kind   = k;
        t.start  = 16'(from);
        t.length = len;
        t.value  = val;
        t.last   = 1'b0;
        expected_tokens.push_back(t);
    endfunction

    task automatic predict_byte(input logic [7:0] b);
        bit    absorbed;
        int    first;
        kind_t single;
        absorbed = 1'b0;
        first    = expected_tokens.size();
        case (scan_mode)
            MODE_IDENT: absorbed = is_letter(b) || is_dec(b);
            MODE_DEC:
                if (is_dec(b))
                begin
                    tok_val  = tok_val * 32'd10 + 32'(b - CH_ZERO);
                    absorbed = 1'b1;
                end
            MODE_ZERO:
                if ((b == CH_LX) || (b == CH_UX))
                begin
                    scan_mode = MODE_HEX;
                    absorbed  = 1'b1;
                end
                else if (is_dec(b))
                begin
                    scan_mode = MODE_DEC;
                    tok_val   = tok_val * 32'd10 + 32'(b - CH_ZERO);
                    absorbed  = 1'b1;
                end
            MODE_HEX:
                if (is_hexch(b))
                begin
                    tok_val  = {tok_val[27:0], hex_nibble(b)};
                    absorbed = 1'b1;
                end
            default: absorbed = 1'b0;
        endcase
        if (absorbed)
        begin
            if (tok_len != LEN_MAX)
                tok_len = tok_len + 16'd1;
            text_pos = text_pos + POSITION_BITS'(1);
            return;
        end
        // byte does not extend the pending token: close it, then start over
        if (scan_mode == MODE_IDENT)
            queue_token(KIND_IDENT, tok_start, tok_len, 32'd0);
        else if (scan_mode != MODE_IDLE)
            queue_token(KIND_NUMBER, tok_start, tok_len, tok_val);
        scan_mode = MODE_IDLE;

        if (b == CH_END)
        begin
            queue_token(KIND_EOF, text_pos, 16'd0, 32'd0);
            text_pos = '0;
        end
        else if (is_blank(b))
            text_pos = text_pos + POSITION_BITS'(1);
        else if (is_letter(b) || is_dec(b))
        begin
            tok_start = text_pos;
            tok_len   = 16'd1;
            if (is_letter(b))
            begin
                scan_mode = MODE_IDENT;
                tok_val   = 32'd0;
            end
            else
            begin
                scan_mode = (b == CH_ZERO) ? MODE_ZERO : MODE_DEC;
                tok_val   = 32'(b - CH_ZERO);
            end
            text_pos = text_pos + POSITION_BITS'(1);
        end
        else
        begin
            case (b)
                CH_LPAREN: single = KIND_LPAREN;
                CH_RPAREN: single = KIND_RPAREN;
                CH_COMMA:  single = KIND_COMMA;
                CH_ASSIGN: single = KIND_ASSIGN;
                CH_SEMI:   single = KIND_SEMI;
                default:   single = KIND_ERROR;
            endcase
            queue_token(single, text_pos, 16'd1, 32'd0);
            text_pos = text_pos + POSITION_BITS'(1);
        end
        if (expected_tokens.size() > first)
            expected_tokens[expected_tokens.size() - 1].last = 1'b1;
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: token %s mismatch: expected %0h, got %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        token_t want;
        if (!rst_n)
        begin
            scan_mode = MODE_IDLE;
            text_pos  = '0;
            tok_start = '0;
            tok_len   = 16'd0;
            tok_val   = 32'd0;
            expected_tokens.delete();
            fail_count    = 0;
            pending_count = 0;
        end
        else
        begin
            if (chars.valid && chars.ready)
                predict_byte(chars.char_byte);
            if (tokens.valid && tokens.ready)
            begin
                if (expected_tokens.size() == 0)
                begin
                    $display("%0t: unexpected token beat: expected none, got kind %0d start %0h",
                             $time, tokens.token_kind, tokens.token_start);
                    fail_count++;
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    check_field("kind", 32'(want.kind), 32'(tokens.token_kind));
                    check_field("start", 32'(want.start), 32'(tokens.token_start));
                    check_field("length", 32'(want.length), 32'(tokens.token_length));
                    check_field("value", want.value, tokens.token_value);
                    check_field("last", 32'(want.last), 32'(tokens.last_of_run));
                end
            end
            pending_count = expected_tokens.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
// Testbench top for byte_stream_tokenizer_core: clock, reset, byte stimulus,
// token back-pressure and the verdict. Depends on bst_pkg, bst_if,
// token_stream_checker and byte_stream_tokenizer_core.
module tb;
    import bst_pkg::*;

    localparam int TOTAL_ITEMS  = 1500;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int LONG_WORD    = 40;  // long identifier sent with no gaps

    logic clk;
    logic rst_n;
    bit   idle_on;
    bit   long_hold;
    int   item_count;
    int   fail_count;
    int   pending_count;

    bst_char_if  chars_if ();
    bst_token_if tokens_if ();

    byte_stream_tokenizer_core #(
        .POSITION_BITS (16)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars_if),
        .tokens (tokens_if)
    );

    token_stream_checker #(
        .POSITION_BITS (16)
    ) u_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .chars         (chars_if),
        .tokens        (tokens_if),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // token sink: random short stalls, one long hold-off on request
    initial
    begin : token_sink
        bit lvl;
        int cycles;
        tokens_if.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (long_hold)
            begin
                lvl       = 1'b0;
                cycles    = HOLD_CYCLES;
                long_hold = 1'b0;
            end
            else if (idle_on && ($urandom_range(0, 4) == 0))
            begin
                lvl    = 1'b0;
                cycles = $urandom_range(1, 4);
            end
            else
            begin
                lvl    = 1'b1;
                cycles = $urandom_range(1, 8);
            end
            tokens_if.ready <= lvl;
            repeat (cycles) @(negedge clk);
        end
    end

    function automatic logic [7:0] pick(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_byte(input logic [7:0] b);
        if (idle_on && ($urandom_range(0, 5) == 0))
        begin
            chars_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        chars_if.valid     <= 1'b1;
        chars_if.char_byte <= b;
        do @(posedge clk); while (!chars_if.ready);
        item_count++;
        @(negedge clk);
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic wait_drained();
        while (pending_count != 0)
            @(negedge clk);
    endtask

    task automatic send_blank();
        logic [7:0] blanks[4];
        blanks = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};
        send_byte(blanks[$urandom_range(0, 3)]);
    endtask

    task automatic send_token();
        int    sel;
        int    n;
        string lead;
        string word;
        string digits;
        string hexd;
        lead   = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
        word   = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
        digits = "0123456789";
        hexd   = "0123456789abcdefABCDEF";
        sel    = $urandom_range(0, 99);
        if (sel < 22)
        begin
            send_byte(pick(lead));
            n = $urandom_range(0, 7);
            repeat (n) send_byte(pick(word));
        end
        else if (sel < 37)
        begin
            // long runs wrap the 32-bit value
            send_byte(pick("123456789"));
            n = $urandom_range(0, 13);
            repeat (n) send_byte(pick(digits));
        end
        else if (sel < 50)
        begin
            send_byte(CH_ZERO);
            send_byte($urandom_range(0, 1) ? CH_LX : CH_UX);
            n = $urandom_range(0, 10);
            repeat (n) send_byte(pick(hexd));
        end
        else if (sel < 56)
        begin
            send_byte(CH_ZERO);
            n = $urandom_range(0, 3);
            repeat (n) send_byte(pick(digits));
        end
        else if (sel < 76)
            send_byte(pick("(),=;"));
        else if (sel < 84)
            send_blank();
        else if (sel < 92)
            send_byte(8'($urandom_range(1, 255)));
        else if (sel < 96)
            send_byte(8'($urandom_range(128, 255)));
        else
            send_byte(CH_END);
        // no separator two times in three so the next byte closes the token
        if ($urandom_range(0, 2) == 0)
            send_blank();
    endtask

    initial
    begin : stimulus
        bit    held;
        bit    paused;
        string word;
        rst_n              = 1'b0;
        chars_if.valid     = 1'b0;
        chars_if.char_byte = 8'h00;
        idle_on            = 1'b1;
        long_hold          = 1'b0;
        item_count         = 0;
        held               = 1'b0;
        paused             = 1'b0;
        word = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: letter and digit extremes, all punctuation, both hex
        // prefixes, prefix with no digits, zero then digit, blanks, errors,
        // end of text flushing a pending number
        send_string("_Zz9(0xAf)0X,07=0x;");
        send_byte(CH_TAB);
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_byte(8'h7F);
        send_byte(8'hFF);
        send_string(" 1");
        send_byte(CH_END);

        // one long identifier with no gaps
        idle_on = 1'b0;
        send_byte(CH_UA);
        repeat (LONG_WORD - 1) send_byte(pick(word));
        send_string("=0x1;");
        send_byte(CH_END);
        idle_on = 1'b1;

        while (item_count < TOTAL_ITEMS)
        begin
            send_token();
            if (!held && (item_count >= 400))
            begin
                long_hold = 1'b1;
                held      = 1'b1;
            end
            if (!paused && (item_count >= 800))
            begin
                paused         = 1'b1;
                chars_if.valid <= 1'b0;
                @(negedge clk);
                wait_drained();
            end
            if (item_count >= 1300)
                idle_on = 1'b0;
        end
        send_byte(CH_END);
        chars_if.valid <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if ((fail_count == 0) && (pending_count == 0))
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
